FILE: sv/fidc_pkg.sv
// ----------------------------------------------------------------------------
// fidc_pkg: shared types and constants
// Widths, exponent constants and the kind codes of the integer/double
// converter.
// ----------------------------------------------------------------------------
`default_nettype none
package fidc_pkg;
   localparam int DefMaxBytes = 8;
   localparam logic KIND_I2D = 1'b0;
   localparam logic KIND_D2I = 1'b1;
   localparam logic [10:0] EXP_BIAS = 11'd1023;
   localparam logic [10:0] EXP_INF  = 11'd2047;

   // One accepted input beat, as held in the input register.
   typedef struct packed {
      logic        kind;
      logic [63:0] value;
   } req_type;
endpackage
`default_nettype wire

FILE: sv/fidc_i2d.sv
// ----------------------------------------------------------------------------
// fidc_i2d: integer to double
// Sign-magnitude split, leading-one search, normalizing shift and packing.
// ----------------------------------------------------------------------------
`default_nettype none
module fidc_i2d import fidc_pkg::*; (
   input  wire logic [63:0] value,
   input  wire logic [3:0]  nbytes,
   output logic [63:0]      result
);
   logic [63:0] mask, sbit, pat, mag;
   logic        neg;
   logic [5:0]  p;
   logic [63:0] norm;

   // Width mask and sign bit for the configured length.
   always_comb begin
      mask = (nbytes >= 4'd8) ? '1 : ((64'd1 << {nbytes[2:0], 3'b000}) - 64'd1);
      sbit = 64'd1 << ({2'b00, nbytes, 3'b000} - 9'd1);
      pat  = value & mask;
      neg  = (pat & sbit) != 64'd0;
      mag  = neg ? ((~pat + 64'd1) & mask) : pat;
   end

   // Leading-one position of the magnitude.
   always_comb begin
      p = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (mag[i]) p = 6'(i);
      end
   end

   // Normalize so the leading one lands in bit 63, then pack.
   always_comb begin
      norm = mag << (6'd63 - p);
      if (pat == 64'd0 || pat == sbit) result = '0;
      else result = {neg, EXP_BIAS + {5'd0, p}, norm[62:11]};
   end
endmodule
`default_nettype wire

FILE: sv/fidc_d2i.sv
// ----------------------------------------------------------------------------
// fidc_d2i: double to integer
// Alignment shift, round half away from zero, range check and negation.
// ----------------------------------------------------------------------------
`default_nettype none
module fidc_d2i import fidc_pkg::*; (
   input  wire logic [63:0] value,
   input  wire logic [3:0]  nbytes,
   output logic [63:0]      result,
   output logic             flag
);
   logic [10:0] ef;
   logic [52:0] m;
   logic [63:0] mag, mask, sh_m, negd;
   logic [5:0]  sh;
   logic [11:0] e;

   always_comb begin
      ef   = value[62:52];
      m    = {1'b1, value[51:0]};
      e    = {1'b0, ef} - {1'b0, EXP_BIAS};
      mask = (nbytes >= 4'd8) ? '1 : ((64'd1 << {nbytes[2:0], 3'b000}) - 64'd1);
      sh   = 6'd52 - e[5:0];
      sh_m = {11'd0, m} >> (sh - 6'd1);
      mag  = '0;
      flag = 1'b0;
      // Exponent classes: non-finite, tiny, half, overflowing, large and fractional.
      if (ef == EXP_INF) flag = 1'b1;
      else if (ef == 11'd0 || ef < 11'd1022) mag = '0;
      else if (ef == 11'd1022) mag = 64'd1;
      else if (e >= 12'd64) flag = 1'b1;
      else if (e >= 12'd52) mag = {11'd0, m} << (e[5:0] - 6'd52);
      else mag = (sh_m >> 1) + {63'd0, sh_m[0]};
      // Overflow past the configured width.
      if (!flag && nbytes < 4'd8 && (mag & ~mask) != 64'd0) flag = 1'b1;
      negd   = value[63] ? (~mag + 64'd1) : mag;
      result = flag ? '0 : (negd & mask);
   end
endmodule
`default_nettype wire

FILE: sv/fixed_int_double_converter_top.sv
// ----------------------------------------------------------------------------
// fixed_int_double_converter_top: integer <-> IEEE double converter
// Converts a two's complement integer of a configured byte length to double
// bits (truncating), or a double to such an integer, rounding half away from zero.
// ----------------------------------------------------------------------------
// Usage: drive req_kind and req_value with start high; a beat is taken at
// each edge where start is high and busy is low. Busy is always low, so a
// beat may be sent in every cycle. Each beat gives one result after passing
// the input register, then the result register, with rsp_valid high
// for exactly one cycle. Throughput is one beat per cycle, set by the single
// combinational pass between the two registers. The receiver cannot stall
// and must take each result in the cycle it is shown. The csr_ channel writes
// int_bytes (0 acts as 1, values above MAX_BYTES act as MAX_BYTES); it is
// always ready and should be written only while idle. Reset clears the
// pipeline valid bits and sets int_bytes to 8.
// ----------------------------------------------------------------------------
`default_nettype none
module fixed_int_double_converter_top import fidc_pkg::*; #(
   parameter int MAX_BYTES = DefMaxBytes
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_kind,
   input  wire logic [63:0] req_value,
   output logic             rsp_valid,
   output logic [63:0]      rsp_converted,
   output logic             rsp_out_of_range,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_int_bytes
);
   req_type     req_ff;
   logic        vin_ff, vout_ff, oor_ff;
   logic [63:0] conv_ff;
   logic [3:0]  nb_ff, nbytes;
   logic [63:0] i2d_res, d2i_res;
   logic        d2i_flag;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Config register and the effective byte length.
   always_ff @(posedge clock) begin
      if (reset) nb_ff <= 4'd8;
      else if (csr_valid) nb_ff <= csr_int_bytes;
   end
   always_comb begin
      nbytes = nb_ff;
      if (nbytes == 4'd0) nbytes = 4'd1;
      if (nbytes > 4'(MAX_BYTES)) nbytes = 4'(MAX_BYTES);
   end

   fidc_i2d u_i2d (.value(req_ff.value), .nbytes(nbytes), .result(i2d_res));
   fidc_d2i u_d2i (.value(req_ff.value), .nbytes(nbytes), .result(d2i_res),
                   .flag(d2i_flag));

   // Input and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         vin_ff  <= 1'b0;
         vout_ff <= 1'b0;
      end else begin
         vin_ff  <= start;
         vout_ff <= vin_ff;
      end
      req_ff.kind  <= req_kind;
      req_ff.value <= req_value;
      conv_ff <= (req_ff.kind == KIND_D2I) ? d2i_res : i2d_res;
      oor_ff  <= (req_ff.kind == KIND_D2I) && d2i_flag;
   end

   assign rsp_valid        = vout_ff;
   assign rsp_converted    = conv_ff;
   assign rsp_out_of_range = oor_ff;
endmodule
`default_nettype wire

FILE: sv/fidc_checker.sv
// ----------------------------------------------------------------------------
// fidc_port_checker: port-level checks
// Latency, kind-0 flag and zero-on-flag checks seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module fidc_port_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        req_kind,
   input wire logic        rsp_valid,
   input wire logic [63:0] rsp_converted,
   input wire logic        rsp_out_of_range
);
   // Every accepted beat gives a result, after the input and result registers.
   a_lat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid) else $error("missing result");
   // No result without an earlier accepted beat.
   a_noinv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2)) else $error("invented result");
   // Integer to double never flags.
   a_i2d: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_kind) |-> ##2 !rsp_out_of_range)
      else $error("flag on integer input");
   // A flagged result carries zero.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> rsp_converted == 64'd0)
      else $error("flagged result not zero");
endmodule

bind fixed_int_double_converter_top fidc_port_checker u_fidc_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_kind(req_kind), .rsp_valid(rsp_valid), .rsp_converted(rsp_converted),
   .rsp_out_of_range(rsp_out_of_range)
);
`default_nettype wire

FILE: tb/fidc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fidc_checker: result predictor and scoreboard for the converter
// Watches the request, result and csr channels, predicts each conversion from
// the current byte length, and compares every result beat in order.
// ----------------------------------------------------------------------------
module fidc_checker import fidc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic        req_kind,
   input  wire logic [63:0] req_value,
   input  wire logic        rsp_valid,
   input  wire logic [63:0] rsp_converted,
   input  wire logic        rsp_out_of_range,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [3:0]  csr_int_bytes,
   output int               fail_count,
   output int               pending
);
   typedef struct packed {
      logic [63:0] converted;
      logic        out_of_range;
   } conv_type;

   conv_type    conv_q[$];
   logic [3:0]  byte_len;

   // Effective byte length after clamping.
   function automatic int eff_len(logic [3:0] r);
      if (r == 0) return 1;
      if (r > 8) return 8;
      return r;
   endfunction

   function automatic logic [63:0] len_mask(int n);
      if (n >= 8) return '1;
      return (64'd1 << (8 * n)) - 1;
   endfunction

   function automatic conv_type convert(logic kind, logic [63:0] v, int n);
      conv_type    r;
      logic [63:0] msk, sb, pat, mag, mant, m;
      logic        neg;
      int          p, e, sh;
      logic [10:0] ef;
      r = '0;
      msk = len_mask(n);
      if (kind == KIND_I2D) begin
         sb = 64'd1 << (8 * n - 1);
         pat = v & msk;
         if (pat == 0 || pat == sb) return r;
         neg = (pat & sb) != 0;
         mag = neg ? ((~pat + 1) & msk) : pat;
         p = 63;
         while (!mag[p]) p--;
         mant = (p > 52) ? (mag >> (p - 52)) : (mag << (52 - p));
         mant[63:52] = '0;
         r.converted = {neg, 63'd0} | (64'(EXP_BIAS + p) << 52) | mant;
         return r;
      end
      ef = v[62:52];
      m = {11'd0, 1'b1, v[51:0]};
      neg = v[63];
      if (ef == EXP_INF) begin
         r.out_of_range = 1;
         return r;
      end
      if (ef == 0) return r;
      e = int'(ef) - 1023;
      if (e <= -2) return r;
      if (e == -1) mag = 1;
      else if (e >= 64) begin
         r.out_of_range = 1;
         return r;
      end else if (e >= 52) mag = m << (e - 52);
      else begin
         sh = 52 - e;
         mag = (m >> sh) + ((m >> (sh - 1)) & 1);
      end
      if (n < 8 && (mag >> (8 * n)) != 0) begin
         r.out_of_range = 1;
         return r;
      end
      if (neg) mag = ~mag + 1;
      r.converted = mag & msk;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   assign pending = conv_q.size();

   // Track the register, predict each request beat, check each result beat.
   always @(posedge clock) begin
      conv_type want;
      if (reset) begin
         byte_len <= 4'd8;
         fail_count = 0;
         conv_q.delete();
      end else begin
         if (rsp_valid) begin
            if (conv_q.size() == 0) begin
               report_mismatch("unexpected beat", rsp_converted, 0);
            end else begin
               want = conv_q.pop_front();
               if (rsp_converted !== want.converted)
                  report_mismatch("converted", rsp_converted, want.converted);
               if (rsp_out_of_range !== want.out_of_range)
                  report_mismatch("out_of_range", rsp_out_of_range, want.out_of_range);
            end
         end
         if (start && !busy)
            conv_q.push_back(convert(req_kind, req_value, eff_len(byte_len)));
         if (csr_valid && csr_ready) byte_len <= csr_int_bytes;
      end
   end
endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top of the integer/double converter testbench
// Drives directed and random conversions over several byte lengths with
// random idle bursts; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
   import fidc_pkg::*;

   logic        clock, reset, start, req_kind, csr_valid;
   logic [63:0] req_value;
   logic [3:0]  csr_int_bytes;
   wire         busy, rsp_valid, rsp_out_of_range, csr_ready;
   wire [63:0]  rsp_converted;
   int          fail_count, pending, cycles;

   fixed_int_double_converter_top u_dut (.*);
   fidc_checker u_chk (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles > 200000) begin
         $display("fixed_int_double_converter_top regression: fail");
         $finish;
      end
   end

   // Send one request beat, holding start until it is taken.
   task automatic send_beat(logic k, logic [63:0] v, bit may_idle);
      int gap;
      if (may_idle && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_kind <= k;
      req_value <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Write the byte length once the pipeline is drained.
   task automatic write_len(logic [3:0] n);
      start <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1;
      csr_int_bytes <= n;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   // Random double: mostly exponents near the integer range.
   function automatic logic [63:0] rand_double(int n);
      logic [63:0] d;
      int          sel;
      d = {$urandom, $urandom};
      sel = $urandom_range(0, 9);
      if (sel < 7) d[62:52] = 11'(1021 + $urandom_range(0, 8 * n + 2));
      else if (sel == 7) d[62:52] = EXP_INF;
      else if (sel == 8) d[62:52] = 11'($urandom_range(0, 1022));
      return d;
   endfunction

   function automatic logic [63:0] rand_int();
      logic [63:0] v;
      v = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) v = v >> $urandom_range(0, 63);
      return v;
   endfunction

   logic [3:0] lens[8] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd4, 4'd2, 4'd9, 4'd8};

   initial begin
      int n;
      start = 0; req_kind = 0; req_value = 0; csr_valid = 0; csr_int_bytes = 0;
      reset = 1; cycles = 0;
      repeat (10) @(posedge clock);
      reset <= 0;

      // Directed: extremes, null pattern, zeros, non-finite, halves, overflow.
      send_beat(KIND_I2D, 64'h8000_0000_0000_0000, 0);
      send_beat(KIND_I2D, 64'h0, 0);
      send_beat(KIND_I2D, 64'hFFFF_FFFF_FFFF_FFFF, 0);
      send_beat(KIND_I2D, 64'h7FFF_FFFF_FFFF_FFFF, 0);
      send_beat(KIND_I2D, 64'h1, 0);
      send_beat(KIND_I2D, 64'h8000_0000_0000_0001, 0);
      send_beat(KIND_D2I, 64'h7FF0_0000_0000_0000, 0);
      send_beat(KIND_D2I, 64'hFFF8_0000_0000_0001, 0);
      send_beat(KIND_D2I, 64'h0, 0);
      send_beat(KIND_D2I, 64'h8000_0000_0000_0000, 0);
      send_beat(KIND_D2I, 64'h000F_FFFF_FFFF_FFFF, 0);
      send_beat(KIND_D2I, 64'h3FE0_0000_0000_0000, 0);
      send_beat(KIND_D2I, 64'hBFE0_0000_0000_0000, 0);
      send_beat(KIND_D2I, 64'h3FDF_FFFF_FFFF_FFFF, 0);
      send_beat(KIND_D2I, 64'h3FF8_0000_0000_0000, 0);
      send_beat(KIND_D2I, 64'hC004_0000_0000_0000, 0);
      send_beat(KIND_D2I, 64'h43E0_0000_0000_0000, 0);
      send_beat(KIND_D2I, 64'hC3E0_0000_0000_0000, 0);
      send_beat(KIND_D2I, 64'h43F0_0000_0000_0000, 0);
      send_beat(KIND_D2I, 64'h7FEF_FFFF_FFFF_FFFF, 0);

      // Random phases over several byte lengths; the last phase has no idling.
      foreach (lens[i]) begin
         write_len(lens[i]);
         n = (lens[i] == 0) ? 1 : (lens[i] > 8 ? 8 : lens[i]);
         if (i == 2) begin
            send_beat(KIND_I2D, 64'hFFFF_FFFF_FFFF_FF80, 0);
            send_beat(KIND_D2I, 64'h405F_E000_0000_0000, 0);
            send_beat(KIND_D2I, 64'h4060_0000_0000_0000, 0);
         end
         repeat (66) begin
            if ($urandom_range(0, 1)) send_beat(KIND_D2I, rand_double(n), i != 7);
            else send_beat(KIND_I2D, rand_int(), i != 7);
         end
      end

      start <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (fail_count == 0) $display("fixed_int_double_converter_top regression: pass");
      else $display("fixed_int_double_converter_top regression: fail");
      $finish;
   end
endmodule

FILE: sim.f
sv/fidc_pkg.sv
sv/fidc_i2d.sv
sv/fidc_d2i.sv
sv/fixed_int_double_converter_top.sv
sv/fidc_checker.sv
tb/fidc_checker.sv
tb/tb.sv
